[src/tsx_pkg.sv]
// Types and constants shared by the Thumb subtract execute unit.
`timescale 1ns / 1ps
`default_nettype none

package tsx_pkg;

   localparam int REG_COUNT = 16;
   localparam int REG_INDEX_WIDTH = 4;
   localparam int DATA_WIDTH = 32;
   localparam int FLAGS_WIDTH = 4;

   localparam logic [REG_INDEX_WIDTH-1:0] SP_INDEX = 4'd13;
   localparam logic [REG_INDEX_WIDTH-1:0] PC_INDEX = 4'd15;

   typedef enum logic [2:0] {
      CMD_RSB        = 3'd0,
      CMD_SBC        = 3'd1,
      CMD_SUB_IMM3   = 3'd2,
      CMD_SUB_IMM8   = 3'd3,
      CMD_SUB_SP     = 3'd4,
      CMD_LOAD_REG   = 3'd5,
      CMD_LOAD_FLAGS = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_type;

   typedef struct packed {
      logic [REG_INDEX_WIDTH-1:0] dest_index;
      logic [DATA_WIDTH-1:0]      dest_value;
      logic                       dest_written;
      logic [FLAGS_WIDTH-1:0]     flags;
      logic                       flags_written;
      logic                       status;
   } result_type;

endpackage

`default_nettype wire

[src/tsx_ram.sv]
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module tsx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

[src/tsx_alu.sv]
// Operand selection, shifter, subtractor and flag logic for one transaction.
`timescale 1ns / 1ps
`default_nettype none

module tsx_alu (
   input  wire  tsx_pkg::cmd_type                      cmd,
   input  wire  logic [31:0]                           instruction,
   input  wire  logic                                  flag_hold,
   input  wire  logic [tsx_pkg::REG_INDEX_WIDTH-1:0]   load_index,
   input  wire  logic [tsx_pkg::DATA_WIDTH-1:0]        load_value,
   input  wire  logic [tsx_pkg::FLAGS_WIDTH-1:0]       load_flags,
   input  wire  logic [tsx_pkg::DATA_WIDTH-1:0]        operand_a,
   input  wire  logic [tsx_pkg::DATA_WIDTH-1:0]        operand_b,
   input  wire  logic [tsx_pkg::FLAGS_WIDTH-1:0]       flags_in,
   output tsx_pkg::result_type                         result
);

   function automatic logic bad_reg(input logic [tsx_pkg::REG_INDEX_WIDTH-1:0] r);
      return (r inside {tsx_pkg::SP_INDEX, tsx_pkg::PC_INDEX});
   endfunction

   function automatic logic [31:0] imm_shift(input logic [31:0] v,
                                             input tsx_pkg::shift_type kind,
                                             input logic [4:0] amount,
                                             input logic carry);
      logic [63:0] doubled;
      logic [31:0] shifted;
      doubled = {v, v} >> amount;
      shifted = 32'd0;
      case (kind)
         tsx_pkg::SHIFT_LSL: begin
            shifted = v << amount;
         end
         tsx_pkg::SHIFT_LSR: begin
            shifted = (amount == 5'd0) ? 32'd0 : (v >> amount);
         end
         tsx_pkg::SHIFT_ASR: begin
            shifted = (amount == 5'd0) ? {32{v[31]}} : 32'($signed(v) >>> amount);
         end
         tsx_pkg::SHIFT_ROR: begin
            shifted = (amount == 5'd0) ? {carry, v[31:1]} : doubled[31:0];
         end
         default: begin
            shifted = v;
         end
      endcase
      return shifted;
   endfunction

   logic [31:0] add_x;
   logic [31:0] add_y;
   logic        add_cin;
   logic [32:0] sum;
   logic [3:0]  sum_flags;
   logic [31:0] rsb_shifted;
   logic        rsb_bad;

   assign rsb_shifted = imm_shift(operand_b, tsx_pkg::shift_type'(instruction[5:4]),
                                  {instruction[14:12], instruction[7:6]}, flags_in[1]);
   assign rsb_bad = bad_reg(instruction[11:8]) || bad_reg(instruction[19:16])
                    || bad_reg(instruction[3:0]);

   always_comb begin
      add_x   = operand_a;
      add_y   = ~operand_b;
      add_cin = 1'b1;
      case (cmd)
         tsx_pkg::CMD_RSB: begin
            add_x = ~operand_a;
            add_y = rsb_shifted;
         end
         tsx_pkg::CMD_SBC: begin
            add_cin = flags_in[1];
         end
         tsx_pkg::CMD_SUB_IMM3: begin
            add_y = ~{29'd0, instruction[8:6]};
         end
         tsx_pkg::CMD_SUB_IMM8: begin
            add_y = ~{24'd0, instruction[7:0]};
         end
         tsx_pkg::CMD_SUB_SP: begin
            add_y = ~{23'd0, instruction[6:0], 2'b00};
         end
         default: begin
            add_x = operand_a;
         end
      endcase
   end

   assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
   assign sum_flags = {sum[31], (sum[31:0] == 32'd0), sum[32],
                       (add_x[31] ^ sum[31]) & (add_y[31] ^ sum[31])};

   always_comb begin
      result       = '0;
      result.flags = flags_in;
      case (cmd)
         tsx_pkg::CMD_RSB: begin
            if (rsb_bad) begin
               result.status = 1'b1;
            end else begin
               result.dest_index   = instruction[11:8];
               result.dest_value   = sum[31:0];
               result.dest_written = 1'b1;
               if (instruction[20]) begin
                  result.flags         = sum_flags;
                  result.flags_written = 1'b1;
               end
            end
         end
         tsx_pkg::CMD_SBC, tsx_pkg::CMD_SUB_IMM3: begin
            result.dest_index   = {1'b0, instruction[2:0]};
            result.dest_value   = sum[31:0];
            result.dest_written = 1'b1;
            if (!flag_hold) begin
               result.flags         = sum_flags;
               result.flags_written = 1'b1;
            end
         end
         tsx_pkg::CMD_SUB_IMM8: begin
            result.dest_index   = {1'b0, instruction[10:8]};
            result.dest_value   = sum[31:0];
            result.dest_written = 1'b1;
            if (!flag_hold) begin
               result.flags         = sum_flags;
               result.flags_written = 1'b1;
            end
         end
         tsx_pkg::CMD_SUB_SP: begin
            result.dest_index   = tsx_pkg::SP_INDEX;
            result.dest_value   = sum[31:0];
            result.dest_written = 1'b1;
         end
         tsx_pkg::CMD_LOAD_REG: begin
            result.dest_index   = load_index;
            result.dest_value   = load_value;
            result.dest_written = 1'b1;
         end
         tsx_pkg::CMD_LOAD_FLAGS: begin
            result.flags         = load_flags;
            result.flags_written = 1'b1;
         end
         default: begin
            result.status = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/thumb_subtract_execute_unit.sv]
// Top level of the Thumb subtract execute unit.
// A transaction accepted into the execute registers has its result registered in the response
// registers once the response is not stalled. Throughput: one transaction per cycle unless
// rsp_stall stalls it; the register file is read when a transaction is accepted and written at
// the end of the execute cycle, with the latest write forwarded. Reset clears the flags, the
// pipeline valid bits and the register valid bits, so every register reads as zero until written.
`timescale 1ns / 1ps
`default_nettype none

module thumb_subtract_execute_unit (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   input  wire  logic                                req_valid,
   output logic                                      req_stall,
   input  wire  logic [2:0]                          req_cmd,
   input  wire  logic [31:0]                         req_instruction,
   input  wire  logic                                req_flag_hold,
   input  wire  logic [tsx_pkg::REG_INDEX_WIDTH-1:0] req_load_index,
   input  wire  logic [tsx_pkg::DATA_WIDTH-1:0]      req_load_value,
   input  wire  logic [tsx_pkg::FLAGS_WIDTH-1:0]     req_load_flags,
   output logic                                      rsp_valid,
   input  wire  logic                                rsp_stall,
   output logic [tsx_pkg::REG_INDEX_WIDTH-1:0]       rsp_dest_index,
   output logic [tsx_pkg::DATA_WIDTH-1:0]            rsp_dest_value,
   output logic                                      rsp_dest_written,
   output logic [tsx_pkg::FLAGS_WIDTH-1:0]           rsp_flags_now,
   output logic                                      rsp_flags_written,
   output logic                                      rsp_status
);

   logic                                 req_accept;
   logic                                 ex_advance;
   logic [tsx_pkg::REG_INDEX_WIDTH-1:0]  rd_addr_a_in;
   logic [tsx_pkg::REG_INDEX_WIDTH-1:0]  rd_addr_b_in;
   logic [tsx_pkg::DATA_WIDTH-1:0]       ram_data_a;
   logic [tsx_pkg::DATA_WIDTH-1:0]       ram_data_b;
   logic [tsx_pkg::DATA_WIDTH-1:0]       operand_a;
   logic [tsx_pkg::DATA_WIDTH-1:0]       operand_b;
   logic                                 reg_write;
   tsx_pkg::result_type                  ex_result;

   logic                                 ex_valid_ff;
   tsx_pkg::cmd_type                     ex_cmd_ff;
   logic [31:0]                          ex_instruction_ff;
   logic                                 ex_flag_hold_ff;
   logic [tsx_pkg::REG_INDEX_WIDTH-1:0]  ex_load_index_ff;
   logic [tsx_pkg::DATA_WIDTH-1:0]       ex_load_value_ff;
   logic [tsx_pkg::FLAGS_WIDTH-1:0]      ex_load_flags_ff;
   logic [tsx_pkg::REG_INDEX_WIDTH-1:0]  ex_addr_a_ff;
   logic [tsx_pkg::REG_INDEX_WIDTH-1:0]  ex_addr_b_ff;

   logic [tsx_pkg::FLAGS_WIDTH-1:0]      flags_ff;
   logic [tsx_pkg::REG_COUNT-1:0]        reg_valid_ff;
   logic                                 last_valid_ff;
   logic [tsx_pkg::REG_INDEX_WIDTH-1:0]  last_index_ff;
   logic [tsx_pkg::DATA_WIDTH-1:0]       last_value_ff;

   logic                                 rsp_valid_ff;
   tsx_pkg::result_type                  rsp_result_ff;

   assign ex_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = ex_valid_ff && !ex_advance;
   assign req_accept = req_valid && !req_stall;
   assign reg_write  = ex_valid_ff && ex_advance && ex_result.dest_written;

   always_comb begin
      rd_addr_a_in = req_instruction[19:16];
      rd_addr_b_in = req_instruction[3:0];
      case (tsx_pkg::cmd_type'(req_cmd))
         tsx_pkg::CMD_RSB: begin
            rd_addr_a_in = req_instruction[19:16];
         end
         tsx_pkg::CMD_SBC: begin
            rd_addr_a_in = {1'b0, req_instruction[2:0]};
            rd_addr_b_in = {1'b0, req_instruction[5:3]};
         end
         tsx_pkg::CMD_SUB_IMM3: begin
            rd_addr_a_in = {1'b0, req_instruction[5:3]};
         end
         tsx_pkg::CMD_SUB_IMM8: begin
            rd_addr_a_in = {1'b0, req_instruction[10:8]};
         end
         tsx_pkg::CMD_SUB_SP: begin
            rd_addr_a_in = tsx_pkg::SP_INDEX;
         end
         default: begin
            rd_addr_b_in = req_instruction[3:0];
         end
      endcase
   end

   tsx_ram #(
      .WIDTH(tsx_pkg::DATA_WIDTH),
      .DEPTH(tsx_pkg::REG_COUNT)
   ) u_reg_ram (
      .clock    (clock),
      .wr_en    (reg_write),
      .wr_addr  (ex_result.dest_index),
      .wr_data  (ex_result.dest_value),
      .rd_en    (req_accept),
      .rd_addr_a(rd_addr_a_in),
      .rd_addr_b(rd_addr_b_in),
      .rd_data_a(ram_data_a),
      .rd_data_b(ram_data_b)
   );

   // A write made at the edge where the operands were read is taken from the forwarding register.
   always_comb begin
      if (last_valid_ff && (last_index_ff == ex_addr_a_ff)) begin
         operand_a = last_value_ff;
      end else if (reg_valid_ff[ex_addr_a_ff]) begin
         operand_a = ram_data_a;
      end else begin
         operand_a = '0;
      end
      if (last_valid_ff && (last_index_ff == ex_addr_b_ff)) begin
         operand_b = last_value_ff;
      end else if (reg_valid_ff[ex_addr_b_ff]) begin
         operand_b = ram_data_b;
      end else begin
         operand_b = '0;
      end
   end

   tsx_alu u_alu (
      .cmd        (ex_cmd_ff),
      .instruction(ex_instruction_ff),
      .flag_hold  (ex_flag_hold_ff),
      .load_index (ex_load_index_ff),
      .load_value (ex_load_value_ff),
      .load_flags (ex_load_flags_ff),
      .operand_a  (operand_a),
      .operand_b  (operand_b),
      .flags_in   (flags_ff),
      .result     (ex_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flags_ff      <= '0;
         reg_valid_ff  <= '0;
         last_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            ex_valid_ff <= 1'b1;
         end else if (ex_advance) begin
            ex_valid_ff <= 1'b0;
         end
         if (ex_advance) begin
            rsp_valid_ff <= ex_valid_ff;
         end
         if (ex_valid_ff && ex_advance) begin
            flags_ff <= ex_result.flags;
         end
         if (reg_write) begin
            reg_valid_ff[ex_result.dest_index] <= 1'b1;
            last_valid_ff                      <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ex_cmd_ff         <= tsx_pkg::cmd_type'(req_cmd);
         ex_instruction_ff <= req_instruction;
         ex_flag_hold_ff   <= req_flag_hold;
         ex_load_index_ff  <= req_load_index;
         ex_load_value_ff  <= req_load_value;
         ex_load_flags_ff  <= req_load_flags;
         ex_addr_a_ff      <= rd_addr_a_in;
         ex_addr_b_ff      <= rd_addr_b_in;
      end
      if (reg_write) begin
         last_index_ff <= ex_result.dest_index;
         last_value_ff <= ex_result.dest_value;
      end
      if (ex_valid_ff && ex_advance) begin
         rsp_result_ff <= ex_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dest_index    = rsp_result_ff.dest_index;
   assign rsp_dest_value    = rsp_result_ff.dest_value;
   assign rsp_dest_written  = rsp_result_ff.dest_written;
   assign rsp_flags_now     = rsp_result_ff.flags;
   assign rsp_flags_written = rsp_result_ff.flags_written;
   assign rsp_status        = rsp_result_ff.status;

endmodule

`default_nettype wire
